FILE: rtl/gem_pkg.sv
// ----------------------------------------------------------------------------
// gem_pkg
// Shared types and constants for the 3x3 gradient edge magnitude block.
// ----------------------------------------------------------------------------
package gem_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 16;
	localparam int GAIN_W    = 8;
	localparam int MODE_W    = 2;
	localparam int CFG_W     = 16;
	localparam int PIX_W     = 8;
	localparam int GRAD_W    = 11;
	localparam int SUM_W     = 21;
	localparam int PROD_W    = SUM_W + 2 * GAIN_W;
	localparam int ROOT_MAX  = 255;

	typedef enum logic [1:0] {
		CFG_IMAGE_WIDTH   = 2'd0,
		CFG_IMAGE_HEIGHT  = 2'd1,
		CFG_GAIN          = 2'd2,
		CFG_OPERATOR_MODE = 2'd3
	} cfg_reg_t;

	localparam logic [MODE_W-1:0] MODE_DIFF    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ROBERTS = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SOBEL   = 2'd2;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
	} pixel_req_t;

	typedef struct packed {
		logic [7:0] magnitude;
		logic       frame_end;
	} edge_res_t;

	typedef struct packed {
		logic accept;
		logic shift;
		logic grad;
		logic square;
		logic scale;
		logic root;
		logic load;
	} gem_cmd_t;

	typedef struct packed {
		logic in_range;
		logic root_done;
		logic out_free;
	} gem_status_t;

endpackage

FILE: rtl/gradient_edge_magnitude.sv
// ----------------------------------------------------------------------------
// gradient_edge_magnitude
// 3x3 gradient magnitude edge detector on an 8-bit raster pixel stream.
//
//   channel  handshake                    payload
//   src      src_valid / src_stall        src_req   (pixel, frame_start)
//   dst      dst_valid / dst_stall        dst_req   (magnitude, frame_end)
//   cfg      cfg_we                       cfg_index, cfg_data
//
// A border pixel goes only through the line store read and window shift; the
// sequencer holds an interior pixel through line store read, window shift,
// gradient, square, scale and an 8-step bit-serial square root.
// One result register: a new pixel is taken while the last result waits.
// arst_n clears counters, window, sequencer and output valid; line stores
// are not cleared.
// ----------------------------------------------------------------------------
module gradient_edge_magnitude (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      src_valid,
	output logic                      src_stall,
	input  gem_pkg::pixel_req_t       src_req,
	output logic                      dst_valid,
	input  logic                      dst_stall,
	output gem_pkg::edge_res_t        dst_req,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [gem_pkg::CFG_W-1:0] cfg_data
);
	import gem_pkg::*;

	gem_cmd_t    cmd;
	gem_status_t status;

	gem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.status    (status),
		.cmd       (cmd)
	);

	gem_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_req   (src_req),
		.cmd       (cmd),
		.status    (status),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_req   (dst_req)
	);

endmodule

FILE: rtl/gem_ctrl.sv
// ----------------------------------------------------------------------------
// gem_ctrl
// Sequencer: steps one pixel request through read and shift and, for an
// in-range pixel, through gradient, square, scale, root and output load.
// ----------------------------------------------------------------------------
module gem_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  gem_pkg::gem_status_t status,
	output gem_pkg::gem_cmd_t    cmd
);
	import gem_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SHIFT  = 7'b0000010,
		ST_GRAD   = 7'b0000100,
		ST_SQUARE = 7'b0001000,
		ST_SCALE  = 7'b0010000,
		ST_ROOT   = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (src_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = status.in_range ? ST_GRAD : ST_IDLE;
			end
			ST_GRAD: begin
				cmd.grad = 1'b1;
				state_d  = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root = 1'b1;
				if (status.root_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign src_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/gem_datapath.sv
// ----------------------------------------------------------------------------
// gem_datapath
// Line stores, 3x3 window, counters, gradient arithmetic, bit-serial root and
// the output register.
// ----------------------------------------------------------------------------
module gem_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [gem_pkg::CFG_W-1:0]     cfg_data,
	input  gem_pkg::pixel_req_t           src_req,
	input  gem_pkg::gem_cmd_t             cmd,
	output gem_pkg::gem_status_t          status,
	output logic                          dst_valid,
	input  logic                          dst_stall,
	output gem_pkg::edge_res_t            dst_req
);
	import gem_pkg::*;

	// configuration
	logic [WIDTH_W-1:0]  image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [MODE_W-1:0]   operator_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= WIDTH_W'(640);
			image_height_q  <= HEIGHT_W'(480);
			gain_q          <= GAIN_W'(1);
			operator_mode_q <= MODE_SOBEL;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[HEIGHT_W-1:0];
				CFG_GAIN:          gain_q          <= cfg_data[GAIN_W-1:0];
				CFG_OPERATOR_MODE: operator_mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry and position of the incoming pixel
	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [COL_W-1:0]    col_q, cur_col;
	logic [HEIGHT_W-1:0] row_q, cur_row;
	logic                col_wrap, row_wrap, in_range, last;

	always_comb begin
		if (image_width_q < WIDTH_W'(3)) begin
			w_eff = WIDTH_W'(3);
		end else if (image_width_q > WIDTH_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = image_width_q;
		end
		h_eff    = (image_height_q < HEIGHT_W'(3)) ? HEIGHT_W'(3) : image_height_q;
		cur_col  = src_req.frame_start ? '0 : col_q;
		cur_row  = src_req.frame_start ? '0 : row_q;
		col_wrap = (WIDTH_W'(cur_col) + WIDTH_W'(1)) >= w_eff;
		row_wrap = ({1'b0, cur_row} + (HEIGHT_W+1)'(1)) >= {1'b0, h_eff};
		in_range = (cur_row >= HEIGHT_W'(2)) && (cur_col >= COL_W'(2)) &&
		           (cur_row < h_eff) && (WIDTH_W'(cur_col) < w_eff);
		last     = (cur_row == h_eff - HEIGHT_W'(1)) &&
		           (WIDTH_W'(cur_col) == w_eff - WIDTH_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : cur_row + HEIGHT_W'(1);
			end else begin
				col_q <= cur_col + COL_W'(1);
				row_q <= cur_row;
			end
		end
	end

	// request latch
	logic [COL_W-1:0] addr_q;
	logic [PIX_W-1:0] px_q;
	logic             in_range_q, last_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q     <= cur_col;
			px_q       <= src_req.pixel;
			in_range_q <= in_range;
			last_q     <= last;
		end
	end

	// line stores
	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [PIX_W-1:0] up_rd_q, mid_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			up_rd_q <= upper_mem[cur_col];
		end
		if (cmd.shift) begin
			upper_mem[addr_q] <= mid_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mid_rd_q <= middle_mem[cur_col];
		end
		if (cmd.shift) begin
			middle_mem[addr_q] <= px_q;
		end
	end

	// 3x3 window, index = 3*row + column, column 2 newest
	logic [PIX_W-1:0] win_q [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= up_rd_q;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= mid_rd_q;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= px_q;
		end
	end

	// gradients
	logic [PIX_W+1:0]          sx_pos, sx_neg, sy_pos, sy_neg;
	logic signed [GRAD_W-1:0]  gx, gy;
	logic signed [GRAD_W-1:0]  gx_q, gy_q;
	logic [2*GAIN_W-1:0]       gain_sq_q;

	always_comb begin
		sx_pos = (PIX_W+2)'(win_q[2]) + {1'b0, win_q[5], 1'b0} + (PIX_W+2)'(win_q[8]);
		sx_neg = (PIX_W+2)'(win_q[0]) + {1'b0, win_q[3], 1'b0} + (PIX_W+2)'(win_q[6]);
		sy_pos = (PIX_W+2)'(win_q[6]) + {1'b0, win_q[7], 1'b0} + (PIX_W+2)'(win_q[8]);
		sy_neg = (PIX_W+2)'(win_q[0]) + {1'b0, win_q[1], 1'b0} + (PIX_W+2)'(win_q[2]);
		case (operator_mode_q)
			MODE_DIFF: begin
				gx = $signed(GRAD_W'(win_q[5])) - $signed(GRAD_W'(win_q[4]));
				gy = $signed(GRAD_W'(win_q[7])) - $signed(GRAD_W'(win_q[4]));
			end
			MODE_ROBERTS: begin
				gx = $signed(GRAD_W'(win_q[8])) - $signed(GRAD_W'(win_q[4]));
				gy = $signed(GRAD_W'(win_q[7])) - $signed(GRAD_W'(win_q[5]));
			end
			default: begin
				gx = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
				gy = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.grad) begin
			gx_q      <= gx;
			gy_q      <= gy;
			gain_sq_q <= gain_q * gain_q;
		end
	end

	// squares, scale, saturation
	logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
	logic [SUM_W-1:0]           sum_q;
	logic [PROD_W-1:0]          prod;
	logic                       sat_q;
	logic [15:0]                s_q;

	assign gx_sq = gx_q * gx_q;
	assign gy_sq = gy_q * gy_q;
	assign prod  = PROD_W'(sum_q) * PROD_W'(gain_sq_q);

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sum_q <= SUM_W'(gx_sq[SUM_W-2:0]) + SUM_W'(gy_sq[SUM_W-2:0]);
		end
		if (cmd.scale) begin
			sat_q <= prod >= PROD_W'(ROOT_MAX * ROOT_MAX);
			s_q   <= prod[15:0];
		end
	end

	// restoring square root, one bit per cycle, msb first
	logic [7:0]  r_q;
	logic [2:0]  k_q;
	logic [7:0]  trial;
	logic [15:0] trial_sq;

	assign trial    = r_q | (8'd1 << k_q);
	assign trial_sq = trial * trial;

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			r_q <= '0;
			k_q <= 3'd7;
		end else if (cmd.root) begin
			if (trial_sq <= s_q) begin
				r_q <= trial;
			end
			k_q <= k_q - 3'd1;
		end
	end

	// output register
	logic dst_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (cmd.load) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dst_req.magnitude <= sat_q ? 8'(ROOT_MAX) : r_q;
			dst_req.frame_end <= last_q;
		end
	end

	assign dst_valid        = dst_valid_q;
	assign status.in_range  = in_range_q;
	assign status.root_done = (k_q == 3'd0);
	assign status.out_free  = !dst_valid_q || !dst_stall;

endmodule
